FILE: hw/rtl/emt_pkg.sv
// shared widths, codes and types for the extent map translator
package emt_pkg;

	localparam int IDX_W    = 6;
	localparam int PHYS_W   = 48;
	localparam int CNT_W    = 32;
	localparam int VIRT_W   = 48;
	localparam int TOTAL_W  = 38;
	localparam int STATUS_W = 2;
	localparam int RANGES_W = 7;

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_XLATE = 1'b1
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_UNMAPPED  = 2'd2
	} status_t;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_WALK  = 6'b000100,
		S_FIN1  = 6'b001000,
		S_FIN2  = 6'b010000,
		S_PUSH  = 6'b100000
	} state_t;

endpackage

FILE: hw/rtl/emt_if.sv
// request and response channel interfaces
interface emt_req_if import emt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [IDX_W-1:0]  entry_index;
	logic [PHYS_W-1:0] entry_phys_start;
	logic [CNT_W-1:0]  entry_sector_count;
	logic [VIRT_W-1:0] xlate_offset;
	logic [VIRT_W-1:0] xlate_length;

	modport source (
		output valid, kind, entry_index, entry_phys_start, entry_sector_count,
			xlate_offset, xlate_length,
		input  ready
	);
	modport sink (
		input  valid, kind, entry_index, entry_phys_start, entry_sector_count,
			xlate_offset, xlate_length,
		output ready
	);
endinterface

interface emt_rsp_if import emt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PHYS_W-1:0]   phys_offset;
	logic [PHYS_W-1:0]   phys_length;
	logic [TOTAL_W-1:0]  total_length;

	modport source (
		output valid, status, phys_offset, phys_length, total_length,
		input  ready
	);
	modport sink (
		input  valid, status, phys_offset, phys_length, total_length,
		output ready
	);
endinterface

FILE: hw/rtl/extent_map_translator.sv
// extent map translator top level: extent table walk under a small sequencer
// the walk reads one entry per cycle over the extents in use; a translation hit
// then passes through S_FIN1 and S_FIN2 before the result is pushed
// a new word is taken only after the previous result has been loaded into the
// output register, which waits while an earlier result still waits for rsp.ready
// reset starts a zeroing pass over all MAX_EXTENTS entries, no word taken, config taken
module extent_map_translator import emt_pkg::*; #(
	parameter int MAX_EXTENTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [RANGES_W-1:0] cfg_wdata,
	emt_req_if.sink             req,
	emt_rsp_if.source           rsp
);
	localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int CW = $clog2(MAX_EXTENTS + 1);
	localparam int XW = (CW > RANGES_W) ? CW : RANGES_W;
	localparam int IW = (AW > IDX_W) ? AW : IDX_W;
	localparam int MW = PHYS_W + CNT_W;

	state_t              state_q;
	logic [RANGES_W-1:0] ranges_q;
	logic [AW-1:0]       clr_q;
	logic [CW-1:0]       rd_cnt_q;
	logic [CW-1:0]       n_q;
	logic                dv_q;
	logic                found_q;
	logic                rsp_valid_q;

	kind_t               kind_q;
	logic                idx_ok_q;
	logic [VIRT_W-1:0]   voff_q;
	logic [VIRT_W-1:0]   vlen_q;
	logic [PHYS_W-1:0]   left_q;
	logic [PHYS_W-1:0]   hit_start_q;
	logic [PHYS_W-1:0]   hit_left_q;
	logic [PHYS_W-1:0]   hit_right_q;
	logic [PHYS_W-1:0]   diff_q;
	logic [PHYS_W-1:0]   room_q;
	status_t             res_status_q;
	logic [PHYS_W-1:0]   res_poff_q;
	logic [PHYS_W-1:0]   res_plen_q;
	logic [TOTAL_W-1:0]  res_total_q;
	status_t             out_status_q;
	logic [PHYS_W-1:0]   out_poff_q;
	logic [PHYS_W-1:0]   out_plen_q;
	logic [TOTAL_W-1:0]  out_total_q;

	logic [CW-1:0]       live;
	logic                accept;
	logic                idx_ok;
	logic [IW-1:0]       idx_x;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [MW-1:0]       ram_wdata;
	logic [MW-1:0]       ram_rdata;
	logic [PHYS_W-1:0]   ent_start;
	logic [PHYS_W-1:0]   right;
	logic                issue;
	logic                hit;
	logic                walk_done;
	logic                push_load;

	// live extent count, register clipped to capacity
	always_comb begin
		if (XW'(ranges_q) > XW'(MAX_EXTENTS)) begin
			live = CW'(MAX_EXTENTS);
		end else begin
			live = CW'(ranges_q);
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign idx_ok    = XW'(req.entry_index) < XW'(live);
	assign idx_x     = IW'(req.entry_index);

	// write port shared by the zeroing pass and extent writes
	assign ram_we    = (state_q == S_CLEAR) ||
		(accept && (req.kind == KIND_WRITE) && idx_ok);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : idx_x[AW-1:0];
	assign ram_wdata = (state_q == S_CLEAR) ? '0 :
		{req.entry_phys_start, req.entry_sector_count};

	emt_ram #(
		.WIDTH (MW),
		.DEPTH (MAX_EXTENTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_cnt_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// walk datapath: one running sum and one span compare per entry
	assign ent_start = ram_rdata[MW-1:CNT_W];
	assign right     = left_q + PHYS_W'(ram_rdata[CNT_W-1:0]);
	assign issue     = (rd_cnt_q != n_q);
	assign hit       = dv_q && !found_q && (kind_q == KIND_XLATE) &&
		(voff_q >= left_q) && (voff_q < right);
	assign walk_done = (state_q == S_WALK) && !issue && !dv_q;
	assign push_load = (state_q == S_PUSH) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			ranges_q    <= '0;
			clr_q       <= '0;
			rd_cnt_q    <= '0;
			n_q         <= '0;
			dv_q        <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ranges_q <= cfg_wdata;
			end
			if (push_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_EXTENTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						n_q      <= live;
						rd_cnt_q <= '0;
						dv_q     <= 1'b0;
						found_q  <= 1'b0;
						state_q  <= S_WALK;
					end
				end
				S_WALK: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					dv_q <= issue;
					if (hit) begin
						found_q <= 1'b1;
					end
					if (walk_done) begin
						if ((kind_q == KIND_XLATE) && found_q) begin
							state_q <= S_FIN1;
						end else begin
							state_q <= S_PUSH;
						end
					end
				end
				S_FIN1: begin
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (push_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind_t'(req.kind);
			idx_ok_q <= idx_ok;
			voff_q   <= req.xlate_offset;
			vlen_q   <= req.xlate_length;
			left_q   <= '0;
		end
		if ((state_q == S_WALK) && dv_q) begin
			left_q <= right;
		end
		if (hit) begin
			hit_start_q <= ent_start;
			hit_left_q  <= left_q;
			hit_right_q <= right;
		end
		if (walk_done) begin
			res_total_q <= left_q[TOTAL_W-1:0];
			res_poff_q  <= '0;
			res_plen_q  <= '0;
			if (kind_q == KIND_WRITE) begin
				res_status_q <= idx_ok_q ? ST_OK : ST_BAD_INDEX;
			end else begin
				res_status_q <= found_q ? ST_OK : ST_UNMAPPED;
			end
		end
		if (state_q == S_FIN1) begin
			diff_q <= voff_q - hit_left_q;
			room_q <= hit_right_q - voff_q;
		end
		if (state_q == S_FIN2) begin
			res_poff_q <= hit_start_q + diff_q;
			res_plen_q <= (vlen_q < room_q) ? vlen_q : room_q;
		end
		if (push_load) begin
			out_status_q <= res_status_q;
			out_poff_q   <= res_poff_q;
			out_plen_q   <= res_plen_q;
			out_total_q  <= res_total_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.phys_offset  = out_poff_q;
	assign rsp.phys_length  = out_plen_q;
	assign rsp.total_length = out_total_q;

endmodule

FILE: hw/rtl/emt_ram.sv
// generic single write port ram with registered read
module emt_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
